// ----- hdl/sbl_pkg.sv -----
// Shared types and constants for the sorted bounded list.
package sbl_pkg;

    localparam int SRC_W   = 16;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 4;
    localparam int CAP_W   = 5;
    localparam int OCNT_W  = 5;
    localparam int ENTRY_W = SRC_W + VAL_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHPRE,
        S_SHIFT,
        S_WRITE,
        S_RDWAIT,
        S_DONE
    } t_state;

    // Result of one entry compare against the operand
    typedef struct packed {
        logic dup;
        logic val_eq;
        logic greater;
    } t_cmp_res;

endpackage

// ----- hdl/sbl_in_if.sv -----
// Input channel: one operation beat.
interface sbl_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic [sbl_pkg::SRC_W-1:0]         source_id;
    logic signed [sbl_pkg::VAL_W-1:0]  value;
    logic [sbl_pkg::IDX_W-1:0]         index;

    modport source (output valid, mode, source_id, value, index, input ready);
    modport sink   (input valid, mode, source_id, value, index, output ready);
endinterface

// ----- hdl/sbl_out_if.sv -----
// Output channel: one result beat.
interface sbl_out_if;
    logic                              valid;
    logic                              ready;
    logic                              accepted;
    logic                              found;
    logic [sbl_pkg::OCNT_W-1:0]        entry_count;
    logic [sbl_pkg::SRC_W-1:0]         read_source;
    logic signed [sbl_pkg::VAL_W-1:0]  read_value;

    modport source (output valid, accepted, found, entry_count, read_source, read_value,
                    input ready);
    modport sink   (input valid, accepted, found, entry_count, read_source, read_value,
                    output ready);
endinterface

// ----- hdl/sorted_bounded_list.sv -----
// Sorted bounded list of (source id, value) pairs, ascending by signed value.
//
// Channels: i_in carries one operation per beat (insert, query, clear, read);
// o_out returns exactly one result beat per operation, with the entry count
// after the operation. i_cfg_we / i_cfg_data write the capacity register;
// the user must write it only while the block is idle; not enforced here.
// Timing: the block takes one operation at a time, ready only when idle.
//   A query scans the entries in order up to a value match or the last one;
//   an insert scans up to the first larger entry, shifts the entries from
//   there up one place and writes, or appends after the last one. The block
//   is ready again as the result shows.
//   The entry store has one read port and one write port, each used once a
//   cycle: the scan reads one entry a cycle, the shift moves one entry a cycle.
// Reset: synchronous, active low; the list becomes empty and capacity
//   returns to 16. No clearing pass is needed.
// Stall: a finished result sits in the output register; a new operation is
//   accepted meanwhile, and its result waits until the register is taken.
module sorted_bounded_list #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sbl_in_if.sink                     i_in,
    sbl_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [sbl_pkg::CAP_W-1:0]  i_cfg_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > sbl_pkg::CAP_W) ? CW : sbl_pkg::CAP_W;
    localparam int IXW  = (CW > sbl_pkg::IDX_W) ? CW : sbl_pkg::IDX_W;

    sbl_pkg::t_state                   r_state, n_state;
    logic [sbl_pkg::CAP_W-1:0]         r_capacity;
    logic [CW-1:0]                     r_fill, n_fill;
    logic [CW-1:0]                     r_k, n_k;
    logic [CW-1:0]                     r_pos, n_pos;
    sbl_pkg::t_mode                    r_op_mode, n_op_mode;
    logic [sbl_pkg::SRC_W-1:0]         r_op_src, n_op_src;
    logic signed [sbl_pkg::VAL_W-1:0]  r_op_val, n_op_val;
    logic                              r_res_acc, n_res_acc;
    logic                              r_res_found, n_res_found;
    logic [sbl_pkg::SRC_W-1:0]         r_res_src, n_res_src;
    logic signed [sbl_pkg::VAL_W-1:0]  r_res_val, n_res_val;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_acc, n_out_acc;
    logic                              r_out_found, n_out_found;
    logic [sbl_pkg::OCNT_W-1:0]        r_out_count, n_out_count;
    logic [sbl_pkg::SRC_W-1:0]         r_out_src, n_out_src;
    logic signed [sbl_pkg::VAL_W-1:0]  r_out_val, n_out_val;

    logic                              in_beat;
    sbl_pkg::t_mode                    in_mode;
    logic                              full;
    logic                              rd_ok;
    logic                              scan_last;
    logic                              out_free;
    logic [CW-1:0]                     k_inc;
    logic [CW-1:0]                     k_dec;
    logic                              mem_we, mem_re;
    logic [AW-1:0]                     mem_waddr, mem_raddr;
    logic [sbl_pkg::ENTRY_W-1:0]       mem_wdata, mem_rdata;
    sbl_pkg::t_cmp_res                 cmp;

    assign in_beat   = i_in.valid && i_in.ready;
    assign in_mode   = sbl_pkg::t_mode'(i_in.mode);
    assign full      = (CMPW'(r_fill) >= CMPW'(r_capacity)) || (r_fill >= CW'(DEPTH));
    assign rd_ok     = (IXW'(i_in.index) < IXW'(r_fill)) && (IXW'(i_in.index) < IXW'(DEPTH));
    assign k_inc     = r_k + 1'b1;
    assign k_dec     = r_k - 1'b1;
    assign scan_last = (k_inc == r_fill);
    assign out_free  = !r_out_valid || o_out.ready;

    sbl_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sbl_cmp u_cmp (
        .i_entry_src (mem_rdata[sbl_pkg::ENTRY_W-1:sbl_pkg::VAL_W]),
        .i_entry_val (mem_rdata[sbl_pkg::VAL_W-1:0]),
        .i_op_src    (r_op_src),
        .i_op_val    (r_op_val),
        .o_res       (cmp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbl_pkg::S_IDLE: begin
                if (in_beat) begin
                    case (in_mode)
                        sbl_pkg::MODE_INSERT: begin
                            if (full) begin
                                n_state = sbl_pkg::S_DONE;
                            end else if (r_fill == '0) begin
                                n_state = sbl_pkg::S_WRITE;
                            end else begin
                                n_state = sbl_pkg::S_SCAN;
                            end
                        end
                        sbl_pkg::MODE_QUERY: begin
                            n_state = (r_fill == '0) ? sbl_pkg::S_DONE : sbl_pkg::S_SCAN;
                        end
                        sbl_pkg::MODE_READ: begin
                            n_state = rd_ok ? sbl_pkg::S_RDWAIT : sbl_pkg::S_DONE;
                        end
                        default: n_state = sbl_pkg::S_DONE;
                    endcase
                end
            end
            sbl_pkg::S_SCAN: begin
                if (r_op_mode == sbl_pkg::MODE_INSERT) begin
                    if (cmp.dup) begin
                        n_state = sbl_pkg::S_DONE;
                    end else if (cmp.greater) begin
                        n_state = sbl_pkg::S_SHPRE;
                    end else if (scan_last) begin
                        n_state = sbl_pkg::S_WRITE;
                    end
                end else if (cmp.val_eq || scan_last) begin
                    n_state = sbl_pkg::S_DONE;
                end
            end
            sbl_pkg::S_SHPRE:  n_state = sbl_pkg::S_SHIFT;
            sbl_pkg::S_SHIFT: begin
                if (r_k == r_pos) begin
                    n_state = sbl_pkg::S_WRITE;
                end
            end
            sbl_pkg::S_WRITE:  n_state = sbl_pkg::S_DONE;
            sbl_pkg::S_RDWAIT: n_state = sbl_pkg::S_DONE;
            sbl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = sbl_pkg::S_IDLE;
                end
            end
            default: n_state = sbl_pkg::S_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_fill      = r_fill;
        n_k         = r_k;
        n_pos       = r_pos;
        n_op_mode   = r_op_mode;
        n_op_src    = r_op_src;
        n_op_val    = r_op_val;
        n_res_acc   = r_res_acc;
        n_res_found = r_res_found;
        n_res_src   = r_res_src;
        n_res_val   = r_res_val;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_acc   = r_out_acc;
        n_out_found = r_out_found;
        n_out_count = r_out_count;
        n_out_src   = r_out_src;
        n_out_val   = r_out_val;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_wdata   = {r_op_src, r_op_val};
        mem_re      = 1'b0;
        mem_raddr   = r_k[AW-1:0];
        case (r_state)
            sbl_pkg::S_IDLE: begin
                mem_re    = in_beat;
                mem_raddr = (in_mode == sbl_pkg::MODE_READ) ? AW'(i_in.index) : '0;
                if (in_beat) begin
                    n_op_mode   = in_mode;
                    n_op_src    = i_in.source_id;
                    n_op_val    = i_in.value;
                    n_k         = '0;
                    n_pos       = '0;
                    n_res_acc   = 1'b0;
                    n_res_found = 1'b0;
                    n_res_src   = '0;
                    n_res_val   = '0;
                    if (in_mode == sbl_pkg::MODE_CLEAR) begin
                        n_fill = '0;
                    end
                end
            end
            sbl_pkg::S_SCAN: begin
                // Read the next entry while comparing this one
                mem_re    = 1'b1;
                mem_raddr = k_inc[AW-1:0];
                if (r_op_mode == sbl_pkg::MODE_INSERT) begin
                    if (cmp.dup) begin
                        n_res_acc = 1'b1;
                    end else if (cmp.greater) begin
                        n_pos = r_k;
                        n_k   = r_fill - 1'b1;
                    end else if (scan_last) begin
                        n_pos = r_fill;
                    end else begin
                        n_k = k_inc;
                    end
                end else if (cmp.val_eq) begin
                    n_res_found = 1'b1;
                end else if (!scan_last) begin
                    n_k = k_inc;
                end
            end
            sbl_pkg::S_SHPRE: begin
                mem_re = 1'b1;
            end
            sbl_pkg::S_SHIFT: begin
                // Move entry up one place, fetch the one below
                mem_we    = 1'b1;
                mem_waddr = k_inc[AW-1:0];
                mem_wdata = mem_rdata;
                if (r_k != r_pos) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_dec[AW-1:0];
                    n_k       = k_dec;
                end
            end
            sbl_pkg::S_WRITE: begin
                mem_we    = 1'b1;
                n_fill    = r_fill + 1'b1;
                n_res_acc = 1'b1;
            end
            sbl_pkg::S_RDWAIT: begin
                n_res_src = mem_rdata[sbl_pkg::ENTRY_W-1:sbl_pkg::VAL_W];
                n_res_val = mem_rdata[sbl_pkg::VAL_W-1:0];
            end
            sbl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_res_acc;
                    n_out_found = r_res_found;
                    n_out_count = sbl_pkg::OCNT_W'(r_fill);
                    n_out_src   = r_res_src;
                    n_out_val   = r_res_val;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbl_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_capacity  <= sbl_pkg::CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_pos       <= n_pos;
        r_op_mode   <= n_op_mode;
        r_op_src    <= n_op_src;
        r_op_val    <= n_op_val;
        r_res_acc   <= n_res_acc;
        r_res_found <= n_res_found;
        r_res_src   <= n_res_src;
        r_res_val   <= n_res_val;
        r_out_acc   <= n_out_acc;
        r_out_found <= n_out_found;
        r_out_count <= n_out_count;
        r_out_src   <= n_out_src;
        r_out_val   <= n_out_val;
    end

    assign i_in.ready        = (r_state == sbl_pkg::S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_out_acc;
    assign o_out.found       = r_out_found;
    assign o_out.entry_count = r_out_count;
    assign o_out.read_source = r_out_src;
    assign o_out.read_value  = r_out_val;

    // Count never passes the built depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("entry count above depth");

    // Count grows only by the final write of an insert
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sbl_pkg::S_WRITE && r_state != sbl_pkg::S_IDLE) |=> $stable(r_fill))
        else $error("entry count changed outside write");

    // Scan stays inside the filled part
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sbl_pkg::S_SCAN |-> r_k < r_fill)
        else $error("scan past count");

    // Shift never walks below the insert position
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sbl_pkg::S_SHIFT |-> (r_k >= r_pos && r_k < r_fill))
        else $error("shift index out of range");

endmodule

// ----- hdl/sbl_mem.sv -----
// Entry store: one write port, one read port with registered data.
module sbl_mem #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [sbl_pkg::ENTRY_W-1:0]       i_wdata,
    input  logic                              i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [sbl_pkg::ENTRY_W-1:0]       o_rdata
);

    logic [sbl_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [sbl_pkg::ENTRY_W-1:0] r_rdata;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read entry, data valid next cycle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sbl_cmp.sv -----
// Shared compare unit: checks one stored entry against the operand.
module sbl_cmp (
    input  logic [sbl_pkg::SRC_W-1:0]         i_entry_src,
    input  logic signed [sbl_pkg::VAL_W-1:0]  i_entry_val,
    input  logic [sbl_pkg::SRC_W-1:0]         i_op_src,
    input  logic signed [sbl_pkg::VAL_W-1:0]  i_op_val,
    output sbl_pkg::t_cmp_res                 o_res
);

    // Exact match, value match and signed order
    always_comb begin
        o_res.val_eq  = (i_entry_val == i_op_val);
        o_res.dup     = o_res.val_eq && (i_entry_src == i_op_src);
        o_res.greater = (i_entry_val > i_op_val);
    end

endmodule
